// ----- src/assert_macros.svh -----
// Assertion macros shared by the sliding window extremum RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check on every rising edge of clk outside reset
`define SWEP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("swep assertion failed");
// Check on every rising edge of clk, reset included
`define SWEP_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("swep reset assertion failed");
`else
`define SWEP_ASSERT(label, prop)
`define SWEP_ASSERT_RST(label, prop)
`endif
`endif

// ----- src/swep_pkg.sv -----
// Shared types and constants of the sliding window extremum block
`default_nettype none
package swep_pkg;

  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEEK_LOWEST       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OLDEST_OCCURRENCE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] WINDOW_LENGTH_RESET = 7'd30;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic load;
    logic scan;
    logic seek_lowest;
    logic oldest;
  } swep_ctrl_t;

endpackage
`default_nettype wire

// ----- src/swep_if.sv -----
// Valid/ready channel interfaces for samples and results
`default_nettype none
interface swep_sample_if #(parameter int SAMPLE_BITS = 32);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface swep_result_if #(parameter int SAMPLE_BITS = 32, parameter int AGE_BITS = 6);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] extreme_value;
  logic [AGE_BITS-1:0]           extreme_age;
  logic                          window_full;
  modport source (output valid, output extreme_value, output extreme_age, output window_full,
                  input ready);
  modport sink   (input valid, input extreme_value, input extreme_age, input window_full,
                  output ready);
endinterface
`default_nettype wire

// ----- src/swep_cell.sv -----
// One window cell: holds a history sample and a running best candidate
`default_nettype none
module swep_cell import swep_pkg::*; #(
  parameter int SAMPLE_BITS = 32,
  parameter int AGE_W       = 6,
  parameter int LEN_W       = 7,
  parameter int CELL_AGE    = 0
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire swep_ctrl_t                    ctrl,
  input  wire logic [LEN_W-1:0]              len_eff,
  input  wire logic signed [SAMPLE_BITS-1:0] shift_in,
  output logic signed [SAMPLE_BITS-1:0]      val_o,
  input  wire logic signed [SAMPLE_BITS-1:0] nb_val,
  input  wire logic [AGE_W-1:0]              nb_age,
  input  wire logic                          nb_vld,
  output logic signed [SAMPLE_BITS-1:0]      cand_val_o,
  output logic [AGE_W-1:0]                   cand_age_o,
  output logic                               cand_vld_o
);

  logic signed [SAMPLE_BITS-1:0] val_r;
  logic signed [SAMPLE_BITS-1:0] cand_val_r;
  logic [AGE_W-1:0]              cand_age_r;
  logic                          cand_vld_r;
  logic                          nb_gt;
  logic                          nb_lt;
  logic                          nb_eq;
  logic                          take;

  assign nb_gt = nb_val > cand_val_r;
  assign nb_lt = nb_val < cand_val_r;
  assign nb_eq = nb_val == cand_val_r;

  // Older neighbor wins when this cell has no valid candidate, when strictly better, or on a tie in oldest mode
  assign take = nb_vld && (!cand_vld_r || (ctrl.seek_lowest ? nb_lt : nb_gt) ||
                           (ctrl.oldest && nb_eq));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_vld_r <= 1'b0;
    end else if (ctrl.load) begin
      val_r      <= shift_in;
      cand_val_r <= shift_in;
      cand_age_r <= AGE_W'(CELL_AGE);
      cand_vld_r <= LEN_W'(CELL_AGE) < len_eff;
    end else if (ctrl.scan && take) begin
      cand_val_r <= nb_val;
      cand_age_r <= nb_age;
      cand_vld_r <= 1'b1;
    end
  end

  assign val_o      = val_r;
  assign cand_val_o = cand_val_r;
  assign cand_age_o = cand_age_r;
  assign cand_vld_o = cand_vld_r;

endmodule
`default_nettype wire

// ----- src/sliding_window_extremum_with_position.sv -----
// Top level of the sliding window extremum with position block
//
// Each accepted sample shifts into a row of WINDOW_MAX cells, cell i holding the
// sample of age i. The same cycle every cell loads itself as a candidate; then,
// once per cycle, each cell keeps the better of its own candidate and that of its
// older neighbor, until cell 0 holds the extremum and its age. The result register
// loads when that reduction running down the cell row is done (with no reduction
// while the window is still filling) and the input is ready again on the next
// cycle; a result register that is still waiting to be taken holds the block in
// its scan state until the result is taken.
// The output register holds a result until taken while the next sample is already
// accepted. Registers: 0 window_length, 1 seek_lowest, 2 oldest_occurrence.
`default_nettype none
`include "assert_macros.svh"
module sliding_window_extremum_with_position import swep_pkg::*; #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  swep_sample_if.sink                in_s,
  swep_result_if.source              out_s,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CMP_W = (LEN_W > CFG_DATA_W) ? LEN_W : CFG_DATA_W;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                        state_r;
  logic [LEN_W-1:0]              cnt_r;
  logic                          full_r;
  logic [LEN_W-1:0]              filled_r;
  logic [CFG_DATA_W-1:0]         window_length_r;
  logic                          seek_lowest_r;
  logic                          oldest_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] extreme_value_r;
  logic [AGE_W-1:0]              extreme_age_r;
  logic                          window_full_r;

  logic [CMP_W-1:0]              wl_ext;
  logic [LEN_W-1:0]              len_eff;
  logic [LEN_W-1:0]              filled_nxt;
  logic                          full_nxt;
  logic                          in_acc;
  logic                          out_free;
  logic                          done;
  swep_ctrl_t                    ctrl;

  logic signed [SAMPLE_BITS-1:0] shift_w    [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] val_w      [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] cand_val_w [WINDOW_MAX+1];
  logic [AGE_W-1:0]              cand_age_w [WINDOW_MAX+1];
  logic                          cand_vld_w [WINDOW_MAX+1];

  // Clamp window length to 1..WINDOW_MAX
  always_comb begin
    wl_ext = CMP_W'(window_length_r);
    if (wl_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (wl_ext > CMP_W'(WINDOW_MAX)) begin
      len_eff = LEN_W'(WINDOW_MAX);
    end else begin
      len_eff = LEN_W'(wl_ext);
    end
  end

  assign filled_nxt = (filled_r == LEN_W'(WINDOW_MAX)) ? filled_r : filled_r + LEN_W'(1);
  assign full_nxt   = filled_nxt >= len_eff;

  assign in_s.ready = (state_r == ST_IDLE);
  assign in_acc     = in_s.valid && in_s.ready;
  assign out_free   = !out_valid_r || out_s.ready;
  assign done       = (state_r == ST_SCAN) && (cnt_r == '0) && out_free;

  assign ctrl.load        = in_acc;
  assign ctrl.scan        = (state_r == ST_SCAN) && (cnt_r != '0);
  assign ctrl.seek_lowest = seek_lowest_r;
  assign ctrl.oldest      = oldest_r;

  // Right edge of the chain offers no candidate
  assign cand_val_w[WINDOW_MAX] = '0;
  assign cand_age_w[WINDOW_MAX] = '0;
  assign cand_vld_w[WINDOW_MAX] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign shift_w[i] = in_s.sample;
    end else begin : g_body
      assign shift_w[i] = val_w[i-1];
    end

    swep_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .AGE_W       (AGE_W),
      .LEN_W       (LEN_W),
      .CELL_AGE    (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .len_eff    (len_eff),
      .shift_in   (shift_w[i]),
      .val_o      (val_w[i]),
      .nb_val     (cand_val_w[i+1]),
      .nb_age     (cand_age_w[i+1]),
      .nb_vld     (cand_vld_w[i+1]),
      .cand_val_o (cand_val_w[i]),
      .cand_age_o (cand_age_w[i]),
      .cand_vld_o (cand_vld_w[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cnt_r           <= '0;
      full_r          <= 1'b0;
      filled_r        <= '0;
      out_valid_r     <= 1'b0;
      window_length_r <= WINDOW_LENGTH_RESET;
      seek_lowest_r   <= 1'b0;
      oldest_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_WINDOW_LENGTH:     window_length_r <= cfg_wdata;
          REG_SEEK_LOWEST:       seek_lowest_r   <= cfg_wdata[0];
          REG_OLDEST_OCCURRENCE: oldest_r        <= cfg_wdata[0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            filled_r <= filled_nxt;
            full_r   <= full_nxt;
            // Skip the reduction while the window is still filling
            cnt_r    <= full_nxt ? len_eff - LEN_W'(1) : '0;
            state_r  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (cnt_r != '0) begin
            cnt_r <= cnt_r - LEN_W'(1);
          end else if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase

      if (done) begin
        out_valid_r     <= 1'b1;
        extreme_value_r <= full_r ? cand_val_w[0] : '0;
        extreme_age_r   <= full_r ? cand_age_w[0] : '0;
        window_full_r   <= full_r;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_s.valid         = out_valid_r;
  assign out_s.extreme_value = extreme_value_r;
  assign out_s.extreme_age   = extreme_age_r;
  assign out_s.window_full   = window_full_r;

  `SWEP_ASSERT(a_accept_starts_scan, in_acc |=> (state_r == ST_SCAN))
  `SWEP_ASSERT(a_scan_counts_down, ((state_r == ST_SCAN) && (cnt_r != '0)) |=> (cnt_r == $past(cnt_r) - LEN_W'(1)))
  `SWEP_ASSERT(a_filled_bound, filled_r <= LEN_W'(WINDOW_MAX))
  `SWEP_ASSERT(a_age_in_window, (out_valid_r && window_full_r) |-> (LEN_W'(extreme_age_r) < len_eff))
  `SWEP_ASSERT(a_partial_is_zero, (out_valid_r && !window_full_r) |-> ((extreme_value_r == '0) && (extreme_age_r == '0)))
  `SWEP_ASSERT_RST(a_reset_clears, !rst_n |=> (!out_valid_r && (state_r == ST_IDLE)))

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sliding window extremum with position block
`timescale 1ns / 100ps

module tb_top;
  import swep_pkg::*;

  localparam int WINDOW_MAX    = 64;
  localparam int SAMPLE_BITS   = 32;
  localparam int AGE_BITS      = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_PHASES = 13;
  localparam int PHASE_ITEMS   = 46;

  // Index 3 has no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic [AGE_BITS-1:0]           age;
    logic                          full;
  } window_result_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [CFG_IDX_W-1:0]          idx;
    logic [CFG_DATA_W-1:0]         wdata;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          typed;
    logic signed [SAMPLE_BITS-1:0] want_value;
    logic [AGE_BITS-1:0]           want_age;
    logic                          want_full;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  swep_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
  swep_result_if #(.SAMPLE_BITS(SAMPLE_BITS), .AGE_BITS(AGE_BITS)) out_if ();

  sliding_window_extremum_with_position #(
    .WINDOW_MAX (WINDOW_MAX),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_if),
    .out_s    (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the block: sample history, fill level and register copies
  logic signed [SAMPLE_BITS-1:0] hist_buf [WINDOW_MAX];
  logic [AGE_BITS-1:0]           next_slot = '0;
  int                            fill_count = 0;
  logic [CFG_DATA_W-1:0]         len_reg = WINDOW_LENGTH_RESET;
  logic                          lowest_reg = 1'b0;
  logic                          oldest_reg = 1'b0;

  window_result_t expected_results[$];
  int errors = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int settings_used = 0;
  int in_stall_pct = 30;
  int out_stall_pct = 30;
  bit quiet = 1'b0;
  int idle_cycles = 0;

  function automatic window_result_t window_extremum(input logic signed [SAMPLE_BITS-1:0] s);
    window_result_t        res;
    logic [AGE_BITS-1:0]   newest;
    logic [AGE_BITS-1:0]   slot;
    logic signed [SAMPLE_BITS-1:0] v;
    int                    span;
    bit                    better;
    newest = next_slot;
    hist_buf[newest] = s;
    next_slot = next_slot + 1'b1;
    if (fill_count < WINDOW_MAX) fill_count++;
    span = (len_reg == 0) ? 1 : (len_reg > WINDOW_MAX) ? WINDOW_MAX : int'(len_reg);
    res = '0;
    if (fill_count < span) return res;
    res.value = hist_buf[newest];
    res.full  = 1'b1;
    for (int a = 1; a < span; a++) begin
      slot = newest - AGE_BITS'(a);
      v = hist_buf[slot];
      better = lowest_reg ? (v < res.value) : (v > res.value);
      if (better || (oldest_reg && v == res.value)) begin
        res.value = v;
        res.age   = AGE_BITS'(a);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("tb_top: result %0d %s mismatch: got %0h, expected %0h",
             results_checked, field, got, want);
    errors++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_WINDOW_LENGTH:     len_reg    = data;
      REG_SEEK_LOWEST:       lowest_reg = data[0];
      REG_OLDEST_OCCURRENCE: oldest_reg = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input bit typed,
                             input window_result_t want);
    window_result_t pred;
    if (!quiet && $urandom_range(0, 99) < in_stall_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    pred = window_extremum(s);
    expected_results.insert(expected_results.size(), typed ? want : pred);
    samples_sent++;
  endtask

  // Hold off the sender until every pending result has been taken
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return SAMPLE_BITS'($signed($urandom_range(0, 6)) - 3);
      2:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom_range(0, 1) ? $urandom : SAMPLE_BITS'($urandom_range(0, 15));
    endcase
  endfunction

  stim_row_t directed_rows [26] = '{
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh7FFF_FFFF, 1'b1, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh8000_0000, 1'b1, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd1, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 6'd0, 1'b1},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh7FFF_FFFF, 1'b1, 32'sh7FFF_FFFF, 6'd0, 1'b1},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd0, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd0, 1'b1, 32'sd0, 6'd0, 1'b1},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd4, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd5, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd5, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, -32'sd3, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd5, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_OLDEST_OCCURRENCE, 7'd1, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd2, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_SEEK_LOWEST, 7'd1, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, -32'sd3, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh8000_0000, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh8000_0000, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_OLDEST_OCCURRENCE, 7'd0, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh8000_0000, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_UNMAPPED, 7'h7F, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sh7FFF_FFFF, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd127, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, 32'sd1, 1'b1, 32'sd0, 6'd0, 1'b0},
    '{ROW_CFG, REG_WINDOW_LENGTH, 7'd64, 32'sd0, 1'b0, 32'sd0, 6'd0, 1'b0},
    '{ROW_SAMPLE, REG_WINDOW_LENGTH, 7'd0, -32'sd1, 1'b1, 32'sd0, 6'd0, 1'b0}
  };

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] phase_len [RANDOM_PHASES];
    window_result_t want;
    logic [CFG_DATA_W-1:0] len_pick;
    phase_len = '{7'd1, 7'd2, 7'd3, 7'd5, 7'd8, 7'd16, 7'd30, 7'd63, 7'd64, 7'd0, 7'd127,
                  7'd65, 7'd7};
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    cfg_we       <= 1'b0;
    cfg_idx      <= REG_WINDOW_LENGTH;
    cfg_wdata    <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        drain_results();
        write_reg(directed_rows[r].idx, directed_rows[r].wdata);
      end else begin
        want = '{directed_rows[r].want_value, directed_rows[r].want_age,
                 directed_rows[r].want_full};
        send_sample(directed_rows[r].sample, directed_rows[r].typed, want);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      len_pick = (p == RANDOM_PHASES - 1) ? CFG_DATA_W'($urandom_range(1, WINDOW_MAX))
                                          : phase_len[p];
      write_reg(REG_WINDOW_LENGTH, len_pick);
      write_reg(REG_SEEK_LOWEST, CFG_DATA_W'(p % 2));
      write_reg(REG_OLDEST_OCCURRENCE, CFG_DATA_W'((p / 2) % 2));
      settings_used++;
      quiet         = (p >= RANDOM_PHASES - 2);
      in_stall_pct  = (p % 4 == 3) ? 0 : $urandom_range(10, 50);
      out_stall_pct = (p % 5 == 4) ? 0 : $urandom_range(10, 50);
      for (int n = 0; n < PHASE_ITEMS; n++) send_sample(pick_sample(), 1'b0, '0);
    end

    drain_results();
    repeat (WINDOW_MAX + 8) @(posedge clk);
    $display("tb_top: %0d samples sent, %0d results checked", samples_sent, results_checked);
    $display("tb_top: %0d random window settings plus directed edge cases", settings_used);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side backpressure
  initial begin
    forever begin
      if (!quiet && $urandom_range(0, 99) < out_stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    window_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        $display("tb_top: unexpected result value %0h age %0d full %0b",
                 out_if.extreme_value, out_if.extreme_age, out_if.window_full);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_if.extreme_value !== want.value)
          report_mismatch("extreme_value", out_if.extreme_value, want.value);
        if (out_if.extreme_age !== want.age)
          report_mismatch("extreme_age", out_if.extreme_age, want.age);
        if (out_if.window_full !== want.full)
          report_mismatch("window_full", out_if.window_full, want.full);
      end
      results_checked++;
    end
  end

  // Watchdog on cycles with no transaction anywhere
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb_top: timeout with %0d results pending", expected_results.size());
      $display("tb_top: errors");
      $finish;
    end
  end

endmodule
